@@ src/bupl_pkg.sv @@
// ----------------------------------------------------------------------------
// bupl_pkg
// Shared constants, codes and types of the bilinear upscaler with palette.
// ----------------------------------------------------------------------------
package bupl_pkg;

    // Source field and palette geometry.
    localparam int FIELD_WIDTH  = 320;
    localparam int FIELD_HEIGHT = 240;
    localparam int PALETTE_BITS = 8;

    localparam int FIELD_CELLS = FIELD_WIDTH * FIELD_HEIGHT;
    localparam int FLD_AW      = $clog2(FIELD_CELLS);
    localparam int BANK_DEPTH  = (FIELD_CELLS + 1) / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int PAL_SIZE    = 1 << PALETTE_BITS;

    // Fixed field widths of the stream items and registers.
    localparam int ACT_W     = 2;
    localparam int ADDR_IN_W = 17;
    localparam int WDATA_W   = 32;
    localparam int PIX_W     = 12;
    localparam int SAMPLE_W  = 16;
    localparam int COLOR_W   = 32;
    localparam int FRAC_W    = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int OFFSET_W  = 8;

    // 9.16 step dividends: (size-1)*65536 - 1.
    localparam int DIV_X       = (FIELD_WIDTH - 1) * 65536 - 1;
    localparam int DIV_Y       = (FIELD_HEIGHT - 1) * 65536 - 1;
    localparam int DIV_MAX     = (DIV_X > DIV_Y) ? DIV_X : DIV_Y;
    localparam int STEP_RAW_W  = $clog2(DIV_MAX + 1);
    localparam int STEP_W      = (STEP_RAW_W < 17) ? 17 : STEP_RAW_W;
    localparam int INT_W       = STEP_W - 16;
    localparam int DIV_CNT_W   = $clog2(STEP_W + 1);
    localparam int CX_W        = $clog2(FIELD_WIDTH);
    localparam int CY_W        = $clog2(FIELD_HEIGHT);

    // Register reset values and the steps that follow from them.
    localparam int RESET_OUT_WIDTH  = 320;
    localparam int RESET_OUT_HEIGHT = 240;
    localparam int STEP_X_RESET     = DIV_X / (RESET_OUT_WIDTH - 1);
    localparam int STEP_Y_RESET     = DIV_Y / (RESET_OUT_HEIGHT - 1);

    // Result buffer.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Item kinds carried in tuser.
    localparam logic [ACT_W-1:0] ACT_FIELD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PALETTE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RENDER  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL_OFFSET = 2'd2;

    // Status of the step divider.
    typedef struct packed {
        logic busy;
        logic done;
    } bupl_div_status_t;

endpackage

@@ src/bupl_step_div.sv @@
// ----------------------------------------------------------------------------
// bupl_step_div
// Restoring divider, one quotient bit per cycle, for the 9.16 step values.
// ----------------------------------------------------------------------------
module bupl_step_div import bupl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [STEP_W-1:0]     dividend,
    input  logic [CFG_W-1:0]      divisor,
    output bupl_div_status_t      status,
    output logic [STEP_W-1:0]     quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [STEP_W-1:0]    quo_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     dsr_reg;

    logic [CFG_W:0]       trial;
    logic                 fits;
    logic [CFG_W-1:0]     rem_next;
    logic [STEP_W-1:0]    quo_next;

    // The dividend shifts out of the top of quo_reg while quotient bits enter below.
    always_comb begin
        trial    = {rem_reg, quo_reg[STEP_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? CFG_W'(trial - {1'b0, dsr_reg}) : trial[CFG_W-1:0];
        quo_next = {quo_reg[STEP_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(STEP_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

@@ src/bupl_field_mem.sv @@
// ----------------------------------------------------------------------------
// bupl_field_mem
// Field sample store: two copies, each split into even and odd banks, so
// that the four neighbours of a cell are read at once.
// ----------------------------------------------------------------------------
module bupl_field_mem import bupl_pkg::*; (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [FLD_AW-1:0]   wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic [FLD_AW-1:0]   rd_base,
    output logic [SAMPLE_W-1:0] nb_a,
    output logic [SAMPLE_W-1:0] nb_b,
    output logic [SAMPLE_W-1:0] nb_c,
    output logic [SAMPLE_W-1:0] nb_d
);

    localparam logic [FLD_AW-1:0] FW_A = FLD_AW'(FIELD_WIDTH);

    // The top copy serves the upper row, the bottom copy the lower row.
    logic [SAMPLE_W-1:0] top_even_mem [BANK_DEPTH];
    logic [SAMPLE_W-1:0] top_odd_mem  [BANK_DEPTH];
    logic [SAMPLE_W-1:0] bot_even_mem [BANK_DEPTH];
    logic [SAMPLE_W-1:0] bot_odd_mem  [BANK_DEPTH];

    logic [SAMPLE_W-1:0] top_even_reg;
    logic [SAMPLE_W-1:0] top_odd_reg;
    logic [SAMPLE_W-1:0] bot_even_reg;
    logic [SAMPLE_W-1:0] bot_odd_reg;
    logic                top_par_reg;
    logic                bot_par_reg;

    logic [FLD_AW-1:0]  base1;
    logic [FLD_AW-1:0]  base0_p1;
    logic [FLD_AW-1:0]  base1_p1;
    logic [BANK_AW-1:0] wr_idx;
    logic [BANK_AW-1:0] top_even_idx;
    logic [BANK_AW-1:0] top_odd_idx;
    logic [BANK_AW-1:0] bot_even_idx;
    logic [BANK_AW-1:0] bot_odd_idx;

    // Of a pair (n, n+1) the even entry sits at (n+1)/2 and the odd one at n/2.
    always_comb begin
        base1        = rd_base + FW_A;
        base0_p1     = rd_base + FLD_AW'(1);
        base1_p1     = base1 + FLD_AW'(1);
        wr_idx       = BANK_AW'(wr_addr >> 1);
        top_even_idx = BANK_AW'(base0_p1 >> 1);
        top_odd_idx  = BANK_AW'(rd_base >> 1);
        bot_even_idx = BANK_AW'(base1_p1 >> 1);
        bot_odd_idx  = BANK_AW'(base1 >> 1);
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_addr[0]) begin
            top_even_mem[wr_idx] <= wr_data;
            bot_even_mem[wr_idx] <= wr_data;
        end
        if (wr_en && wr_addr[0]) begin
            top_odd_mem[wr_idx] <= wr_data;
            bot_odd_mem[wr_idx] <= wr_data;
        end
        top_even_reg <= top_even_mem[top_even_idx];
        top_odd_reg  <= top_odd_mem[top_odd_idx];
        bot_even_reg <= bot_even_mem[bot_even_idx];
        bot_odd_reg  <= bot_odd_mem[bot_odd_idx];
        top_par_reg  <= rd_base[0];
        bot_par_reg  <= base1[0];
    end

    assign nb_a = top_par_reg ? top_odd_reg  : top_even_reg;
    assign nb_b = top_par_reg ? top_even_reg : top_odd_reg;
    assign nb_c = bot_par_reg ? bot_odd_reg  : bot_even_reg;
    assign nb_d = bot_par_reg ? bot_even_reg : bot_odd_reg;

endmodule

@@ src/bupl_palette_mem.sv @@
// ----------------------------------------------------------------------------
// bupl_palette_mem
// Palette colour store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bupl_palette_mem import bupl_pkg::*; (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [PALETTE_BITS-1:0] wr_addr,
    input  logic [COLOR_W-1:0]      wr_data,
    input  logic [PALETTE_BITS-1:0] rd_addr,
    output logic [COLOR_W-1:0]      rd_data
);

    logic [COLOR_W-1:0] pal_mem [PAL_SIZE];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pal_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= pal_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/bupl_out_fifo.sv @@
// ----------------------------------------------------------------------------
// bupl_out_fifo
// Result buffer between the free-running datapath and the output channel.
// ----------------------------------------------------------------------------
module bupl_out_fifo import bupl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [COLOR_W-1:0] push_data,
    input  logic               pop,
    output logic               out_valid,
    output logic [COLOR_W-1:0] out_data
);

    logic [COLOR_W-1:0]    fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_mem[rd_ptr_reg];

endmodule

@@ src/bilinear_upscale_palette_lookup_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_upscale_palette_lookup_core
// Bilinear upscaler of a stored sample field with a palette colour lookup.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ----------------------------------------------------
//  s_axis   in         tuser: action; tdata: address, write_data, pixel_x,
//                      pixel_y (field or palette write, or a pixel to render)
//  m_axis   out        tdata: color (one beat for each render beat)
//  cfg      in         write enable, register index, data (no read-back)
//
// The datapath takes one beat per cycle and runs free: a render beat's colour
// is written into the result buffer through the pipeline registers and then
// shows on m_axis, and write beats take effect in the same order as renders,
// so a render always sees the writes that came before it. s_axis_tready falls
// only when the sixteen-entry result buffer has no room left for an
// outstanding render, or while a step value is being recomputed: each write of
// out_width or out_height starts a bit-serial division. Reset is synchronous;
// the sample and palette stores are not cleared by it.
//
module bilinear_upscale_palette_lookup_core import bupl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [16:0] address, [48:17] write_data, [60:49] pixel_x, [72:61] pixel_y,
    // [79:73] zero
    input  logic [79:0]          s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]     s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] color
    output logic [COLOR_W-1:0]   m_axis_tdata
);

    // Field positions within s_axis_tdata.
    localparam int ADDR_LO = 0;
    localparam int DATA_LO = ADDR_LO + ADDR_IN_W;
    localparam int PX_LO   = DATA_LO + WDATA_W;
    localparam int PY_LO   = PX_LO + PIX_W;

    localparam logic [INT_W-1:0]  IX_MAX = INT_W'(FIELD_WIDTH - 2);
    localparam logic [INT_W-1:0]  IY_MAX = INT_W'(FIELD_HEIGHT - 2);
    localparam logic [FLD_AW-1:0] FW_A   = FLD_AW'(FIELD_WIDTH);

    // lerp(p, q, f) = p + floor((q - p) * f / 256); an arithmetic shift floors.
    function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] p,
                                                 input logic [SAMPLE_W-1:0] q,
                                                 input logic [FRAC_W-1:0]   f);
        logic signed [SAMPLE_W:0]            diff;
        logic signed [FRAC_W:0]              fs;
        logic signed [SAMPLE_W+FRAC_W+1:0]   prod;
        logic signed [SAMPLE_W+1:0]          part;
        logic signed [SAMPLE_W+1:0]          sum;
        diff = signed'({1'b0, q}) - signed'({1'b0, p});
        fs   = signed'({1'b0, f});
        prod = diff * fs;
        part = prod[SAMPLE_W+FRAC_W+1:FRAC_W];
        sum  = signed'({2'b00, p}) + part;
        return sum[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and step values
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    out_width_reg;
    logic [CFG_W-1:0]    out_height_reg;
    logic [OFFSET_W-1:0] palette_offset_reg;
    logic [STEP_W-1:0]   step_x_reg;
    logic [STEP_W-1:0]   step_y_reg;
    logic                pend_x_reg;
    logic                pend_y_reg;
    logic                div_axis_y_reg;

    logic [CFG_W-1:0]    w_m1;
    logic [CFG_W-1:0]    h_m1;
    logic                div_start;
    logic                div_pick_y;
    logic [STEP_W-1:0]   div_dividend;
    logic [CFG_W-1:0]    div_divisor;
    bupl_div_status_t    div_stat;
    logic [STEP_W-1:0]   div_quotient;
    logic                step_busy;

    // A size of zero behaves as one, so the last index is then zero.
    always_comb begin
        w_m1 = (out_width_reg  == '0) ? '0 : out_width_reg  - CFG_W'(1);
        h_m1 = (out_height_reg == '0) ? '0 : out_height_reg - CFG_W'(1);
    end

    // The divider serves both axes; a pending width update goes first.
    always_comb begin
        div_start    = (pend_x_reg || pend_y_reg) && !div_stat.busy;
        div_pick_y   = !pend_x_reg;
        div_dividend = div_pick_y ? STEP_W'(DIV_Y) : STEP_W'(DIV_X);
        if (div_pick_y) begin
            div_divisor = (h_m1 == '0) ? CFG_W'(1) : h_m1;
        end else begin
            div_divisor = (w_m1 == '0) ? CFG_W'(1) : w_m1;
        end
        step_busy = pend_x_reg || pend_y_reg || div_stat.busy;
    end

    bupl_step_div u_step_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_stat),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_width_reg      <= CFG_W'(RESET_OUT_WIDTH);
            out_height_reg     <= CFG_W'(RESET_OUT_HEIGHT);
            palette_offset_reg <= '0;
            step_x_reg         <= STEP_W'(STEP_X_RESET);
            step_y_reg         <= STEP_W'(STEP_Y_RESET);
            pend_x_reg         <= 1'b0;
            pend_y_reg         <= 1'b0;
            div_axis_y_reg     <= 1'b0;
        end else begin
            if (div_stat.done) begin
                if (div_axis_y_reg) begin
                    step_y_reg <= div_quotient;
                end else begin
                    step_x_reg <= div_quotient;
                end
            end
            if (div_start) begin
                div_axis_y_reg <= div_pick_y;
                if (div_pick_y) begin
                    pend_y_reg <= 1'b0;
                end else begin
                    pend_x_reg <= 1'b0;
                end
            end
            // A write landing during a division simply queues another one.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_OUT_WIDTH: begin
                        out_width_reg <= cfg_wr_data;
                        pend_x_reg    <= 1'b1;
                    end
                    CFG_OUT_HEIGHT: begin
                        out_height_reg <= cfg_wr_data;
                        pend_y_reg     <= 1'b1;
                    end
                    CFG_PAL_OFFSET: begin
                        palette_offset_reg <= cfg_wr_data[OFFSET_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and result credits
    // ------------------------------------------------------------------
    logic                  s_beat;
    logic                  s_render;
    logic                  m_beat;
    logic [FIFO_CNT_W-1:0] credit_reg;
    logic [FIFO_CNT_W-1:0] credit_next;

    // Every render beat taken holds a place in the result buffer until its
    // colour leaves, so the buffer never overflows and the pipe never stalls.
    assign s_axis_tready = !step_busy && (credit_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign s_render      = s_beat && (s_axis_tuser == ACT_RENDER);
    assign m_beat        = m_axis_tvalid && m_axis_tready;

    always_comb begin
        credit_next = credit_reg;
        if (s_render && !m_beat) begin
            credit_next = credit_reg + FIFO_CNT_W'(1);
        end else if (!s_render && m_beat) begin
            credit_next = credit_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath pipeline
    // ------------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic p5_valid_reg, p6_valid_reg, p7_render_reg;

    logic [ACT_W-1:0] p1_act_reg, p2_act_reg, p3_act_reg, p4_act_reg;
    logic [ACT_W-1:0] p5_act_reg, p6_act_reg;
    logic [ADDR_IN_W-1:0] p1_addr_reg, p2_addr_reg, p3_addr_reg, p4_addr_reg;
    logic [ADDR_IN_W-1:0] p5_addr_reg, p6_addr_reg;
    logic [WDATA_W-1:0] p1_data_reg, p2_data_reg, p3_data_reg, p4_data_reg;
    logic [WDATA_W-1:0] p5_data_reg, p6_data_reg;

    logic [PIX_W-1:0]    p1_px_reg, p1_py_reg;
    logic [STEP_W-1:0]   p2_ax_reg, p2_ay_reg;
    logic [FLD_AW-1:0]   p3_base_reg;
    logic [FRAC_W-1:0]   p3_fx_reg, p3_fy_reg, p4_fx_reg, p4_fy_reg, p5_fy_reg;
    logic [SAMPLE_W-1:0] p5_top_reg, p5_bot_reg, p6_v_reg;

    // Stage 1: clamp the pixel to the output size and scale by the step.
    logic [PIX_W-1:0]        px_c;
    logic [PIX_W-1:0]        py_c;
    logic [STEP_W+PIX_W-1:0] ax_full;
    logic [STEP_W+PIX_W-1:0] ay_full;

    always_comb begin
        px_c    = (CFG_W'(p1_px_reg) > w_m1) ? w_m1[PIX_W-1:0] : p1_px_reg;
        py_c    = (CFG_W'(p1_py_reg) > h_m1) ? h_m1[PIX_W-1:0] : p1_py_reg;
        ax_full = step_x_reg * px_c;
        ay_full = step_y_reg * py_c;
    end

    // Stage 2: split into cell and fraction, then form the linear base index.
    logic [INT_W-1:0]  ix_wide, iy_wide;
    logic [INT_W-1:0]  ix_g, iy_g;
    logic [FLD_AW-1:0] base0;

    always_comb begin
        ix_wide = p2_ax_reg[STEP_W-1:16];
        iy_wide = p2_ay_reg[STEP_W-1:16];
        ix_g    = (ix_wide > IX_MAX) ? IX_MAX : ix_wide;
        iy_g    = (iy_wide > IY_MAX) ? IY_MAX : iy_wide;
        base0   = FLD_AW'(CY_W'(iy_g)) * FW_A + FLD_AW'(CX_W'(ix_g));
    end

    // Stage 3: field store access (write, or read of four neighbours).
    logic                field_wr_en;
    logic [SAMPLE_W-1:0] nb_a, nb_b, nb_c, nb_d;

    assign field_wr_en = p3_valid_reg && (p3_act_reg == ACT_FIELD)
                         && (32'(p3_addr_reg) < 32'(FIELD_CELLS));

    bupl_field_mem u_field_mem (
        .aclk    (aclk),
        .wr_en   (field_wr_en),
        .wr_addr (FLD_AW'(p3_addr_reg)),
        .wr_data (p3_data_reg[SAMPLE_W-1:0]),
        .rd_base (p3_base_reg),
        .nb_a    (nb_a),
        .nb_b    (nb_b),
        .nb_c    (nb_c),
        .nb_d    (nb_d)
    );

    // Stage 6: palette access at the blended value plus offset.
    logic [SAMPLE_W-1:0]     idx_sum;
    logic                    pal_wr_en;
    logic [COLOR_W-1:0]      pal_color;

    assign idx_sum   = p6_v_reg + SAMPLE_W'(palette_offset_reg);
    assign pal_wr_en = p6_valid_reg && (p6_act_reg == ACT_PALETTE)
                       && (32'(p6_addr_reg) < 32'(PAL_SIZE));

    bupl_palette_mem u_palette_mem (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (PALETTE_BITS'(p6_addr_reg)),
        .wr_data (p6_data_reg),
        .rd_addr (idx_sum[PALETTE_BITS-1:0]),
        .rd_data (pal_color)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            p7_render_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= s_beat;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            p6_valid_reg  <= p5_valid_reg;
            p7_render_reg <= p6_valid_reg && (p6_act_reg == ACT_RENDER);
        end
    end

    always_ff @(posedge aclk) begin
        p1_act_reg  <= s_axis_tuser;
        p1_addr_reg <= s_axis_tdata[DATA_LO-1:ADDR_LO];
        p1_data_reg <= s_axis_tdata[PX_LO-1:DATA_LO];
        p1_px_reg   <= s_axis_tdata[PY_LO-1:PX_LO];
        p1_py_reg   <= s_axis_tdata[PY_LO+PIX_W-1:PY_LO];

        p2_act_reg  <= p1_act_reg;
        p2_addr_reg <= p1_addr_reg;
        p2_data_reg <= p1_data_reg;
        p2_ax_reg   <= ax_full[STEP_W-1:0];
        p2_ay_reg   <= ay_full[STEP_W-1:0];

        p3_act_reg  <= p2_act_reg;
        p3_addr_reg <= p2_addr_reg;
        p3_data_reg <= p2_data_reg;
        p3_base_reg <= base0;
        p3_fx_reg   <= p2_ax_reg[15:8];
        p3_fy_reg   <= p2_ay_reg[15:8];

        p4_act_reg  <= p3_act_reg;
        p4_addr_reg <= p3_addr_reg;
        p4_data_reg <= p3_data_reg;
        p4_fx_reg   <= p3_fx_reg;
        p4_fy_reg   <= p3_fy_reg;

        // Stage 4: blend along x on both rows.
        p5_act_reg  <= p4_act_reg;
        p5_addr_reg <= p4_addr_reg;
        p5_data_reg <= p4_data_reg;
        p5_fy_reg   <= p4_fy_reg;
        p5_top_reg  <= blend(nb_a, nb_b, p4_fx_reg);
        p5_bot_reg  <= blend(nb_c, nb_d, p4_fx_reg);

        // Stage 5: blend along y.
        p6_act_reg  <= p5_act_reg;
        p6_addr_reg <= p5_addr_reg;
        p6_data_reg <= p5_data_reg;
        p6_v_reg    <= blend(p5_top_reg, p5_bot_reg, p5_fy_reg);
    end

    // ------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------
    bupl_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p7_render_reg),
        .push_data (pal_color),
        .pop       (m_beat),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ test/bupl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bupl_checker
// Watches the beats of the bilinear upscaler, keeps its own copy of the sample
// field, the palette and the registers, predicts each rendered colour and
// compares it with the result beats in order.
// ----------------------------------------------------------------------------
module bupl_checker import bupl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [79:0]          s_axis_tdata,
    input  logic [ACT_W-1:0]     s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [COLOR_W-1:0]   m_axis_tdata,
    output int                   error_count,
    output int                   pending_colors
);

    logic [SAMPLE_W-1:0] sample_mem [FIELD_CELLS];
    logic [COLOR_W-1:0]  colour_mem [PAL_SIZE];
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COLOR_W-1:0]  expected_colors [$];

    // Linear blend with an 8-bit fraction, rounding towards minus infinity.
    function automatic int mix_frac(int p, int q, int f);
        int prod;
        prod = (q - p) * f;
        return p + (prod >>> 8);
    endfunction

    function automatic logic [COLOR_W-1:0] shade_pixel(logic [PIX_W-1:0] px,
                                                       logic [PIX_W-1:0] py);
        int unsigned w, h, step_x, step_y, x, y, ax, ay, col, row, base, index;
        int fx, fy, upper, lower, level;
        w = (width_reg == 0) ? 1 : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        step_x = DIV_X / ((w > 1) ? w - 1 : 1);
        step_y = DIV_Y / ((h > 1) ? h - 1 : 1);
        x = (px > w - 1) ? w - 1 : px;
        y = (py > h - 1) ? h - 1 : py;
        ax = step_x * x;
        ay = step_y * y;
        col = ax >> 16;
        row = ay >> 16;
        fx = (ax >> 8) & 255;
        fy = (ay >> 8) & 255;
        if (col > FIELD_WIDTH - 2) col = FIELD_WIDTH - 2;
        if (row > FIELD_HEIGHT - 2) row = FIELD_HEIGHT - 2;
        base = row * FIELD_WIDTH + col;
        upper = mix_frac(sample_mem[base], sample_mem[base + 1], fx);
        lower = mix_frac(sample_mem[base + FIELD_WIDTH],
                         sample_mem[base + FIELD_WIDTH + 1], fx);
        level = mix_frac(upper, lower, fy);
        index = (level + offset_reg) % PAL_SIZE;
        return colour_mem[index];
    endfunction

    always @(posedge aclk) begin
        logic [COLOR_W-1:0] want;
        logic [16:0]        addr;
        logic [31:0]        data;
        if (!aresetn) begin
            width_reg  = CFG_W'(RESET_OUT_WIDTH);
            height_reg = CFG_W'(RESET_OUT_HEIGHT);
            offset_reg = '0;
            expected_colors.delete();
            pending_colors <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OUT_WIDTH:  width_reg = cfg_wr_data;
                    CFG_OUT_HEIGHT: height_reg = cfg_wr_data;
                    CFG_PAL_OFFSET: offset_reg = cfg_wr_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                addr = s_axis_tdata[16:0];
                data = s_axis_tdata[48:17];
                case (s_axis_tuser)
                    ACT_FIELD: begin
                        if (addr < FIELD_CELLS) sample_mem[addr] = data[SAMPLE_W-1:0];
                    end
                    ACT_PALETTE: begin
                        if (addr < PAL_SIZE) colour_mem[PALETTE_BITS'(addr)] = data;
                    end
                    ACT_RENDER: begin
                        expected_colors.push_back(shade_pixel(s_axis_tdata[60:49],
                                                              s_axis_tdata[72:61]));
                    end
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: colour beat with nothing expected, expected none, actual %08h",
                             $time, m_axis_tdata);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_colors.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: colour mismatch, expected %08h, actual %08h",
                                 $time, want, m_axis_tdata);
                        error_count <= error_count + 1;
                    end
                end
            end
            pending_colors <= expected_colors.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bilinear upscaler with palette lookup.
// Loads the palette, runs a directed set of corner beats, then walks through a
// series of register settings with random writes and renders. Every render is
// preceded by writes of any of its four source samples not yet loaded, so no
// unwritten entry is ever read. The checker beside the block does all the
// predicting and comparing.
// ----------------------------------------------------------------------------
module testbench;
    import bupl_pkg::*;

    // Far beyond the slowest correct run of a few thousand beats with stalls.
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 28;
    localparam int HOLD_CYCLES = 400;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_OUT_WIDTH;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [79:0]          s_axis_tdata = '0;
    logic [ACT_W-1:0]     s_axis_tuser = ACT_FIELD;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [COLOR_W-1:0]   m_axis_tdata;

    int error_count;
    int pending_colors;
    int cycle_count = 0;

    // Idling switches for each side, and the request for one long hold-off.
    bit sender_gaps = 1'b0;
    bit receiver_gaps = 1'b0;
    bit hold_off_request = 1'b0;

    // Which field samples have been loaded, and the output size in force, so
    // that renders only ever touch loaded samples.
    bit          sample_loaded [FIELD_CELLS];
    int unsigned size_x = RESET_OUT_WIDTH;
    int unsigned size_y = RESET_OUT_HEIGHT;

    bilinear_upscale_palette_lookup_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bupl_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .error_count    (error_count),
        .pending_colors (pending_colors)
    );

    always #1 aclk = ~aclk;

    // Watchdog: a run that has not finished by now has hung somewhere.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side. Outside the one long hold-off it either accepts freely or,
    // when idling is switched on, drops tready for random bursts.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_request = 1'b0;
            end
            if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // Offers one beat and returns at the falling edge after it was taken,
    // leaving tvalid high so that back-to-back beats need no gap.
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [16:0] addr,
                             input logic [31:0] data, input logic [PIX_W-1:0] px,
                             input logic [PIX_W-1:0] py);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_axis_tuser  = act;
        s_axis_tdata  = {7'd0, py, px, data, addr};
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        if (act == ACT_FIELD && addr < FIELD_CELLS) sample_loaded[addr] = 1'b1;
    endtask

    // Top-left source sample of the cell that an output pixel falls into.
    function automatic int unsigned cell_base(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        int unsigned w, h, x, y, col, row;
        w = (size_x == 0) ? 1 : size_x;
        h = (size_y == 0) ? 1 : size_y;
        x = (px > w - 1) ? w - 1 : px;
        y = (py > h - 1) ? h - 1 : py;
        col = ((DIV_X / ((w > 1) ? w - 1 : 1)) * x) >> 16;
        row = ((DIV_Y / ((h > 1) ? h - 1 : 1)) * y) >> 16;
        if (col > FIELD_WIDTH - 2) col = FIELD_WIDTH - 2;
        if (row > FIELD_HEIGHT - 2) row = FIELD_HEIGHT - 2;
        return row * FIELD_WIDTH + col;
    endfunction

    // A render beat, preceded by writes of its neighbours: always for samples
    // not yet loaded, and, with refresh_ok set, at random for the others so the blend sees fresh data.
    task automatic render_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                                input bit refresh_ok);
        int unsigned base;
        int unsigned nb_index;
        base = cell_base(px, py);
        for (int k = 0; k < 4; k++) begin
            nb_index = base + (k % 2) + (k / 2) * FIELD_WIDTH;
            if (!sample_loaded[nb_index] || (refresh_ok && $urandom_range(0, 2) == 0))
                send_beat(ACT_FIELD, 17'(nb_index), $urandom, 12'($urandom), 12'($urandom));
        end
        send_beat(ACT_RENDER, 17'($urandom), $urandom, px, py);
    endtask

    // Coordinates mostly anywhere, often at or just past the configured edge.
    function automatic logic [PIX_W-1:0] pick_coord(int unsigned size);
        int unsigned lim;
        lim = (size == 0) ? 0 : size - 1;
        if (lim > 4095) lim = 4095;
        case ($urandom_range(0, 3)) inside
            [0:1]:   return 12'($urandom_range(0, 4095));
            2:       return 12'($urandom_range(0, lim));
            default: return 12'(lim + $urandom_range(0, 1));
        endcase
    endfunction

    // One random beat; the unused action is noise and does not count.
    task automatic random_beat(output bit counted);
        int r;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < 50) begin
            render_pixel(pick_coord(size_x), pick_coord(size_y), 1'b1);
        end else if (r < 75) begin
            send_beat(ACT_FIELD, ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                 : 17'($urandom_range(0, FIELD_CELLS - 1)),
                      $urandom, 12'($urandom), 12'($urandom));
        end else if (r < 92) begin
            send_beat(ACT_PALETTE, ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                   : 17'($urandom_range(0, PAL_SIZE - 1)),
                      $urandom, 12'($urandom), 12'($urandom));
        end else begin
            send_beat(ACT_UNUSED, 17'($urandom), $urandom, 12'($urandom), 12'($urandom));
            counted = 1'b0;
        end
    endtask

    // Registers change only with the block idle: the input is parked, every
    // colour is back, and the last write beats have had time to leave the
    // seven-stage pipeline.
    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned offset);
        s_axis_tvalid = 1'b0;
        while (pending_colors != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = CFG_OUT_WIDTH;
        cfg_wr_data = CFG_W'(w);
        @(negedge aclk);
        cfg_index   = CFG_OUT_HEIGHT;
        cfg_wr_data = CFG_W'(h);
        @(negedge aclk);
        cfg_index   = CFG_PAL_OFFSET;
        cfg_wr_data = CFG_W'(offset);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        size_x = w;
        size_y = h;
    endtask

    initial begin
        int unsigned widths  [PHASES] = '{1, 0, 4096, 8191, 2, 320, 0, 0, 0, 0};
        int unsigned heights [PHASES] = '{1, 0, 4096, 2, 8191, 240, 0, 0, 0, 0};
        int unsigned offsets [PHASES] = '{255, 17, 0, 128, 200, 0, 0, 0, 0, 0};
        int counted_beats;
        bit counted;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Load the whole palette first, so that any index a render lands on
        // has a colour behind it.
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        for (int i = 0; i < PAL_SIZE; i++)
            send_beat(ACT_PALETTE, 17'(i), $urandom, 12'($urandom), 12'($urandom));

        // Directed beats under the reset-time size of 320 by 240.
        send_beat(ACT_FIELD, 17'(FIELD_CELLS - 1), 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
        send_beat(ACT_FIELD, 17'(FIELD_CELLS), 32'h0000_1234, 12'h000, 12'h000);
        send_beat(ACT_FIELD, 17'h1FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'h000);
        send_beat(ACT_PALETTE, 17'(PAL_SIZE), 32'hDEAD_BEEF, 12'h000, 12'hFFF);
        send_beat(ACT_PALETTE, 17'h1FFFF, 32'h0000_0000, 12'h000, 12'h000);
        send_beat(ACT_PALETTE, 17'd0, 32'hFFFF_FFFF, 12'h000, 12'h000);
        send_beat(ACT_PALETTE, 17'(PAL_SIZE - 1), 32'h0000_0000, 12'h000, 12'h000);
        send_beat(ACT_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
        // Opposite extremes on the two diagonals of the first cell, blended at
        // the largest fraction: strongly negative and positive differences.
        send_beat(ACT_FIELD, 17'd0, 32'h0000_FFFF, 12'h000, 12'h000);
        send_beat(ACT_FIELD, 17'd1, 32'hFFFF_0000, 12'h000, 12'h000);
        send_beat(ACT_FIELD, 17'(FIELD_WIDTH), 32'h0000_0000, 12'h000, 12'h000);
        send_beat(ACT_FIELD, 17'(FIELD_WIDTH + 1), 32'h0000_FFFF, 12'h000, 12'h000);
        render_pixel(12'd1, 12'd1, 1'b0);
        render_pixel(12'd0, 12'd0, 1'b0);
        render_pixel(12'd319, 12'd239, 1'b1);
        render_pixel(12'd4095, 12'd4095, 1'b1);
        render_pixel(12'd0, 12'd4095, 1'b1);
        render_pixel(12'd4095, 12'd0, 1'b1);
        render_pixel(12'd160, 12'd120, 1'b1);

        // One phase per register setting: fixed extremes first (single-pixel
        // output, zero sizes, the largest sizes, lopsided ones, the reset size), then random.
        for (int p = 0; p < PHASES; p++) begin
            if (p >= 6) begin
                widths[p]  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                         : $urandom_range(1, 4096);
                heights[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                         : $urandom_range(1, 4096);
                offsets[p] = $urandom_range(0, 255);
            end
            configure(widths[p], heights[p], offsets[p]);
            if (p == PHASES - 1) begin
                // The closing stretch runs with both sides flat out.
                sender_gaps = 1'b0;
                receiver_gaps = 1'b0;
            end else begin
                sender_gaps = ($urandom_range(0, 2) != 0);
                receiver_gaps = ($urandom_range(0, 2) != 0);
            end
            // Once the sizes are back at 320 by 240, the result side stops
            // for a long while and the result buffer fills up behind it: more
            // renders follow than the buffer has places.
            if (p == 5) begin
                hold_off_request = 1'b1;
                repeat (FIFO_DEPTH + 4)
                    render_pixel(pick_coord(size_x), pick_coord(size_y), 1'b0);
            end
            counted_beats = 0;
            while (counted_beats < PHASE_BEATS) begin
                random_beat(counted);
                if (counted) counted_beats++;
            end
        end

        s_axis_tvalid = 1'b0;
        while (pending_colors != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);

        if (error_count == 0 && pending_colors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
